// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MDC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mdc_pkg.sv =====
// package for the maze carver: codes, types, direction order table, edge mask
package mdc_pkg;

	localparam int MDC_MAX_NODES_X = 32;
	localparam int MDC_MAX_NODES_Y = 32;

	// node coordinates never exceed the 5-bit start node fields
	localparam int NODE_W = 5;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	localparam logic [1:0] CFG_MAZE_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_MAZE_HEIGHT  = 2'd1;
	localparam logic [1:0] CFG_START_NODE_X = 2'd2;
	localparam logic [1:0] CFG_START_NODE_Y = 2'd3;

	typedef enum logic [2:0] {
		KIND_STARTED  = 3'd0,
		KIND_CARVED   = 3'd1,
		KIND_BLOCKED  = 3'd2,
		KIND_POPPED   = 3'd3,
		KIND_FINISHED = 3'd4,
		KIND_BADCFG   = 3'd5
	} kind_t;

	// direction codes, also the bit position in a direction mask
	localparam logic [1:0] DIR_L = 2'd0;
	localparam logic [1:0] DIR_R = 2'd1;
	localparam logic [1:0] DIR_U = 2'd2;
	localparam logic [1:0] DIR_D = 2'd3;

	localparam int ORDER_COUNT = 24;

	// try order, first direction in the top two bits
	typedef logic [7:0] order_t;

	localparam order_t ORDER_TABLE [ORDER_COUNT] = '{
		{DIR_L, DIR_R, DIR_U, DIR_D}, {DIR_L, DIR_R, DIR_D, DIR_U},
		{DIR_L, DIR_U, DIR_R, DIR_D}, {DIR_L, DIR_U, DIR_D, DIR_R},
		{DIR_L, DIR_D, DIR_R, DIR_U}, {DIR_L, DIR_D, DIR_U, DIR_R},
		{DIR_R, DIR_L, DIR_U, DIR_D}, {DIR_R, DIR_L, DIR_D, DIR_U},
		{DIR_R, DIR_U, DIR_L, DIR_D}, {DIR_R, DIR_U, DIR_D, DIR_L},
		{DIR_R, DIR_D, DIR_L, DIR_U}, {DIR_R, DIR_D, DIR_U, DIR_L},
		{DIR_U, DIR_L, DIR_R, DIR_D}, {DIR_U, DIR_L, DIR_D, DIR_R},
		{DIR_U, DIR_R, DIR_L, DIR_D}, {DIR_U, DIR_R, DIR_D, DIR_L},
		{DIR_U, DIR_D, DIR_L, DIR_R}, {DIR_U, DIR_D, DIR_R, DIR_L},
		{DIR_D, DIR_L, DIR_R, DIR_U}, {DIR_D, DIR_L, DIR_U, DIR_R},
		{DIR_D, DIR_R, DIR_L, DIR_U}, {DIR_D, DIR_R, DIR_U, DIR_L},
		{DIR_D, DIR_U, DIR_L, DIR_R}, {DIR_D, DIR_U, DIR_R, DIR_L}
	};

	typedef struct packed {
		logic       found;
		logic       in_grid;
		logic [3:0] new_mask;
		logic [3:0] push_mask;
		logic [5:0] dest_nx;
		logic [5:0] dest_ny;
		logic [5:0] path_cx;
		logic [5:0] path_cy;
		logic [5:0] dest_cx;
		logic [5:0] dest_cy;
	} step_res_t;

	// directions from a node that stay inside the node grid
	function automatic logic [3:0] edge_mask(logic [5:0] x, logic [5:0] y,
		logic [5:0] nw, logic [5:0] nh);
		logic [3:0] m;
		m        = '0;
		m[DIR_L] = (x != 6'd0);
		m[DIR_R] = (6'(x + 6'd1) != nw);
		m[DIR_U] = (y != 6'd0);
		m[DIR_D] = (6'(y + 6'd1) != nh);
		return m;
	endfunction

endpackage

// ===== hdl/mdc_ram.sv =====
// generic single write port ram with registered read
module mdc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/mdc_step.sv =====
// step unit: picks the next direction of the top node and works out its neighbor
module mdc_step import mdc_pkg::*; #(
	parameter int MAX_NODES_X = MDC_MAX_NODES_X,
	parameter int MAX_NODES_Y = MDC_MAX_NODES_Y,
	localparam int AW = $clog2(MAX_NODES_X * MAX_NODES_Y)
) (
	input  logic [5:0]    cur_x,
	input  logic [5:0]    cur_y,
	input  logic [3:0]    dirs,
	input  order_t        order,
	input  logic [5:0]    node_w,
	input  logic [5:0]    node_h,
	output step_res_t     res,
	output logic [AW-1:0] addr
);

	logic       found;
	logic [1:0] dir;
	logic [1:0] code;
	logic [5:0] dx;
	logic [5:0] dy;
	logic [5:0] px;
	logic [5:0] py;
	logic [5:0] c2x;
	logic [5:0] c2y;
	logic       in_grid;

	always_comb begin
		found = 1'b0;
		dir   = DIR_L;
		for (int k = 0; k < 4; k++) begin
			code = order[7 - 2 * k -: 2];
			if (!found && dirs[code]) begin
				found = 1'b1;
				dir   = code;
			end
		end
	end

	assign c2x = {cur_x[4:0], 1'b0};
	assign c2y = {cur_y[4:0], 1'b0};

	always_comb begin
		dx      = cur_x;
		dy      = cur_y;
		px      = c2x;
		py      = c2y;
		in_grid = 1'b1;
		unique case (dir)
			DIR_L: begin
				if (cur_x == 6'd0) begin
					in_grid = 1'b0;
				end else begin
					dx = cur_x - 6'd1;
					px = c2x - 6'd1;
				end
			end
			DIR_R: begin
				dx = cur_x + 6'd1;
				px = c2x + 6'd1;
			end
			DIR_U: begin
				if (cur_y == 6'd0) begin
					in_grid = 1'b0;
				end else begin
					dy = cur_y - 6'd1;
					py = c2y - 6'd1;
				end
			end
			DIR_D: begin
				dy = cur_y + 6'd1;
				py = c2y + 6'd1;
			end
			default: ;
		endcase
		if (dx >= node_w || dy >= node_h || 32'(dx) >= MAX_NODES_X ||
			32'(dy) >= MAX_NODES_Y) begin
			in_grid = 1'b0;
		end
	end

	always_comb begin
		res.found     = found;
		res.in_grid   = in_grid;
		res.new_mask  = dirs & ~(4'b0001 << dir);
		res.push_mask = edge_mask(dx, dy, node_w, node_h);
		res.dest_nx   = dx;
		res.dest_ny   = dy;
		res.path_cx   = px;
		res.path_cy   = py;
		res.dest_cx   = {dx[4:0], 1'b0};
		res.dest_cy   = {dy[4:0], 1'b0};
	end

	assign addr = AW'(AW'(dy) * AW'(MAX_NODES_X) + AW'(dx));

endmodule

// ===== hdl/maze_dfs_carver_core.sv =====
// top level of the maze carver: config registers, sequencer, stack and visited memories
//
// usage: write maze_width, maze_height, start_node_x and start_node_y through the
// cfg_we / cfg_index / cfg_wdata port while the block is idle. a word is taken at a
// clock edge with start high and busy low; cmd selects a new maze or one search step.
// every word gives exactly one result word: done is high for one cycle with kind,
// path_x/y and dest_x/y valid, and the receiver has to take it in that cycle.
// a step that carves or is blocked goes through the stack read, the direction pick with
// the visited read, and the result; a step that pops ends at the direction pick. each
// memory has a registered read, and a new word is taken only once the sequencer is back
// in idle. a good start sweeps the whole visited memory one entry a cycle and then
// reports; a bad config start or a step on an empty stack answers straight from idle.
// busy is high while the sequencer is out of idle.
// reset empties the stack and loads the config registers with their defaults; the
// visited memory is not touched until the first good start clears it.
module maze_dfs_carver_core import mdc_pkg::*; #(
	parameter int MAX_NODES_X = MDC_MAX_NODES_X,
	parameter int MAX_NODES_Y = MDC_MAX_NODES_Y
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       cmd,
	input  logic [4:0] try_order,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_wdata,
	output logic       done,
	output logic [2:0] kind,
	output logic [5:0] path_x,
	output logic [5:0] path_y,
	output logic [5:0] dest_x,
	output logic [5:0] dest_y
);

	`include "assert_macros.svh"

	localparam int NODE_COUNT = MAX_NODES_X * MAX_NODES_Y;
	localparam int AW         = $clog2(NODE_COUNT);
	localparam int DW         = $clog2(NODE_COUNT + 1);
	localparam int XW_RAW     = $clog2(MAX_NODES_X);
	localparam int YW_RAW     = $clog2(MAX_NODES_Y);
	localparam int XW         = (XW_RAW > NODE_W) ? NODE_W : XW_RAW;
	localparam int YW         = (YW_RAW > NODE_W) ? NODE_W : YW_RAW;
	localparam int SEW        = XW + YW + 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DIR,
		ST_VIS
	} state_t;

	state_t     state_q;
	logic [5:0] maze_width_q;
	logic [5:0] maze_height_q;
	logic [4:0] start_x_q;
	logic [4:0] start_y_q;

	logic          done_q;
	kind_t         kind_q;
	logic [5:0]    path_x_q;
	logic [5:0]    path_y_q;
	logic [5:0]    dest_x_q;
	logic [5:0]    dest_y_q;
	logic [DW-1:0] depth_q;
	logic [AW-1:0] sweep_q;
	order_t        order_q;
	step_res_t     step_q;
	logic [AW-1:0] dest_addr_q;

	logic [6:0]     w_inc;
	logic [6:0]     h_inc;
	logic [5:0]     node_w;
	logic [5:0]     node_h;
	logic           cfg_ok;
	logic           accept;
	logic [4:0]     ord_idx;
	logic [AW-1:0]  start_addr;
	logic [5:0]     start_cx;
	logic [5:0]     start_cy;
	logic           carve;

	logic           stk_we;
	logic [AW-1:0]  stk_waddr;
	logic [SEW-1:0] stk_wdata;
	logic [AW-1:0]  stk_raddr;
	logic [SEW-1:0] stk_rdata;

	logic           vis_we;
	logic [AW-1:0]  vis_waddr;
	logic           vis_wdata;
	logic           vis_rdata;

	step_res_t      res;
	logic [AW-1:0]  res_addr;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maze_width_q  <= 6'd63;
			maze_height_q <= 6'd63;
			start_x_q     <= 5'd0;
			start_y_q     <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAZE_WIDTH:   maze_width_q  <= cfg_wdata;
				CFG_MAZE_HEIGHT:  maze_height_q <= cfg_wdata;
				CFG_START_NODE_X: start_x_q     <= cfg_wdata[4:0];
				CFG_START_NODE_Y: start_y_q     <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// node grid size and start checks
	assign w_inc  = {1'b0, maze_width_q} + 7'd1;
	assign h_inc  = {1'b0, maze_height_q} + 7'd1;
	assign node_w = w_inc[6:1];
	assign node_h = h_inc[6:1];
	assign cfg_ok = maze_width_q[0] && maze_height_q[0] &&
		(6'(start_x_q) < node_w) && (6'(start_y_q) < node_h) &&
		(32'(node_w) <= MAX_NODES_X) && (32'(node_h) <= MAX_NODES_Y);

	assign start_addr = AW'(AW'(start_y_q) * AW'(MAX_NODES_X) + AW'(start_x_q));
	assign start_cx   = {start_x_q, 1'b0};
	assign start_cy   = {start_y_q, 1'b0};

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign ord_idx = (try_order >= 5'(ORDER_COUNT)) ?
		try_order - 5'(ORDER_COUNT) : try_order;

	assign stk_raddr = AW'(depth_q - DW'(1));
	assign carve     = step_q.in_grid && !vis_rdata;

	mdc_step #(
		.MAX_NODES_X(MAX_NODES_X),
		.MAX_NODES_Y(MAX_NODES_Y)
	) u_step (
		.cur_x (6'(stk_rdata[SEW-1 -: XW])),
		.cur_y (6'(stk_rdata[YW+3 -: YW])),
		.dirs  (stk_rdata[3:0]),
		.order (order_q),
		.node_w(node_w),
		.node_h(node_h),
		.res   (res),
		.addr  (res_addr)
	);

	// stack write port
	always_comb begin
		stk_we    = 1'b0;
		stk_waddr = stk_raddr;
		stk_wdata = stk_rdata;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd == CMD_START && cfg_ok) begin
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = {XW'(start_x_q), YW'(start_y_q),
						edge_mask(6'(start_x_q), 6'(start_y_q), node_w, node_h)};
				end
			end
			ST_DIR: begin
				if (res.found) begin
					stk_we    = 1'b1;
					stk_wdata = {stk_rdata[SEW-1:4], res.new_mask};
				end
			end
			ST_VIS: begin
				if (carve && depth_q < DW'(NODE_COUNT)) begin
					stk_we    = 1'b1;
					stk_waddr = AW'(depth_q);
					stk_wdata = {XW'(step_q.dest_nx), YW'(step_q.dest_ny),
						step_q.push_mask};
				end
			end
			default: ;
		endcase
	end

	// visited write port: clearing sweep or marking a new node
	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = dest_addr_q;
		vis_wdata = 1'b1;
		if (state_q == ST_CLEAR) begin
			vis_we    = 1'b1;
			vis_waddr = sweep_q;
			vis_wdata = (sweep_q == start_addr);
		end else if (state_q == ST_VIS && carve) begin
			vis_we = 1'b1;
		end
	end

	mdc_ram #(
		.WIDTH(SEW),
		.DEPTH(NODE_COUNT)
	) u_stack_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	mdc_ram #(
		.WIDTH(1),
		.DEPTH(NODE_COUNT)
	) u_visited_ram (
		.clk  (clk),
		.we   (vis_we),
		.waddr(vis_waddr),
		.wdata(vis_wdata),
		.raddr(res_addr),
		.rdata(vis_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			kind_q      <= KIND_STARTED;
			path_x_q    <= '0;
			path_y_q    <= '0;
			dest_x_q    <= '0;
			dest_y_q    <= '0;
			depth_q     <= '0;
			sweep_q     <= '0;
			order_q     <= '0;
			step_q      <= '0;
			dest_addr_q <= '0;
		end else begin
			done_q   <= 1'b0;
			path_x_q <= '0;
			path_y_q <= '0;
			dest_x_q <= '0;
			dest_y_q <= '0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_START) begin
							if (cfg_ok) begin
								depth_q <= DW'(1);
								sweep_q <= '0;
								state_q <= ST_CLEAR;
							end else begin
								depth_q <= '0;
								done_q  <= 1'b1;
								kind_q  <= KIND_BADCFG;
							end
						end else if (depth_q == '0) begin
							done_q <= 1'b1;
							kind_q <= KIND_FINISHED;
						end else begin
							order_q <= ORDER_TABLE[ord_idx];
							state_q <= ST_DIR;
						end
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(NODE_COUNT - 1)) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						kind_q   <= KIND_STARTED;
						path_x_q <= start_cx;
						path_y_q <= start_cy;
						dest_x_q <= start_cx;
						dest_y_q <= start_cy;
					end
				end
				ST_DIR: begin
					if (!res.found) begin
						depth_q <= depth_q - DW'(1);
						done_q  <= 1'b1;
						kind_q  <= KIND_POPPED;
						state_q <= ST_IDLE;
					end else begin
						step_q      <= res;
						dest_addr_q <= res_addr;
						state_q     <= ST_VIS;
					end
				end
				ST_VIS: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (carve) begin
						kind_q   <= KIND_CARVED;
						path_x_q <= step_q.path_cx;
						path_y_q <= step_q.path_cy;
						dest_x_q <= step_q.dest_cx;
						dest_y_q <= step_q.dest_cy;
						if (depth_q < DW'(NODE_COUNT)) begin
							depth_q <= depth_q + DW'(1);
						end
					end else begin
						kind_q <= KIND_BLOCKED;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign kind   = kind_q;
	assign path_x = path_x_q;
	assign path_y = path_y_q;
	assign dest_x = dest_x_q;
	assign dest_y = dest_y_q;

	// a result word only leaves when the sequencer is back in idle
	`MDC_ASSERT(a_done_idle, !done || !busy, "result word while busy")
	// the stack never holds more nodes than MAX_NODES_X * MAX_NODES_Y
	`MDC_ASSERT(a_depth_max, depth_q <= DW'(NODE_COUNT), "stack depth overflow")
	// a step on an empty stack reports finished in the next cycle
	`MDC_ASSERT_NEXT(a_empty_step, accept && cmd == CMD_STEP && depth_q == '0,
		done && kind == KIND_FINISHED, "empty stack step not finished")
	// a carved word always goes with exactly one push
	`MDC_ASSERT(a_carve_push, !(done && kind == KIND_CARVED) ||
		depth_q == $past(depth_q) + DW'(1), "carve without push")

endmodule

// ===== tb/sv/maze_dfs_carver_core_test.sv =====
// testbench for maze_dfs_carver_core: directed and random start/step words checked against a maze search predictor
module maze_dfs_carver_core_test;
	import mdc_pkg::*;

	localparam int NODE_TOTAL = MDC_MAX_NODES_X * MDC_MAX_NODES_Y;
	localparam int WORD_TARGET = 600;
	localparam int CALM_FROM = 540;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] path_x;
		logic [5:0] path_y;
		logic [5:0] dest_x;
		logic [5:0] dest_y;
	} maze_event_t;

	typedef struct {
		logic       is_cfg;
		logic [1:0] reg_index;
		logic [5:0] value;
		logic       word_cmd;
		logic [4:0] order;
		logic       may_idle;
	} plan_entry_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       cmd = CMD_START;
	logic [4:0] try_order = 5'd0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_MAZE_WIDTH;
	logic [5:0] cfg_wdata = 6'd0;
	logic       busy;
	logic       done;
	logic [2:0] kind;
	logic [5:0] path_x;
	logic [5:0] path_y;
	logic [5:0] dest_x;
	logic [5:0] dest_y;

	maze_dfs_carver_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.try_order(try_order),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.kind(kind),
		.path_x(path_x),
		.path_y(path_y),
		.dest_x(dest_x),
		.dest_y(dest_y)
	);

	// predictor state
	logic [5:0]  m_width = 6'd63;
	logic [5:0]  m_height = 6'd63;
	logic [4:0]  m_start_x = 5'd0;
	logic [4:0]  m_start_y = 5'd0;
	logic        node_seen [NODE_TOTAL];
	logic [4:0]  trail_x [NODE_TOTAL];
	logic [4:0]  trail_y [NODE_TOTAL];
	logic [3:0]  trail_dirs [NODE_TOTAL];
	logic [10:0] trail_depth = 11'd0;

	maze_event_t maze_events_due [$];
	plan_entry_t word_plan [$];
	int          err_count = 0;
	int          gap_left = 0;
	int          quiet = 0;
	logic        cur_may_idle = 1'b0;
	logic        plan_idle = 1'b1;
	int          planned = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_mismatch(input string msg);
		if (err_count < 100)
			$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic void apply_config(logic [1:0] idx, logic [5:0] val);
		case (idx)
			CFG_MAZE_WIDTH:   m_width = val;
			CFG_MAZE_HEIGHT:  m_height = val;
			CFG_START_NODE_X: m_start_x = val[4:0];
			CFG_START_NODE_Y: m_start_y = val[4:0];
		endcase
	endfunction

	function automatic void push_node(int nx, int ny, int nw, int nh);
		logic [3:0] m;
		if (trail_depth >= NODE_TOTAL)
			return;
		m = '0;
		m[DIR_L] = (nx != 0);
		m[DIR_R] = (nx + 1 != nw);
		m[DIR_U] = (ny != 0);
		m[DIR_D] = (ny + 1 != nh);
		trail_x[trail_depth] = 5'(nx);
		trail_y[trail_depth] = 5'(ny);
		trail_dirs[trail_depth] = m;
		trail_depth++;
	endfunction

	function automatic maze_event_t predict_carve(logic word_cmd, logic [4:0] order_idx);
		maze_event_t r;
		int nw, nh, cx, cy, nxt_x, nxt_y, px, py, rem, sel;
		int fact [4];
		logic [1:0] pool [4];
		logic [1:0] try_dir [4];
		logic [1:0] dir;
		logic found, in_grid, ok;
		r = '0;
		nw = (int'(m_width) + 1) / 2;
		nh = (int'(m_height) + 1) / 2;
		if (word_cmd == CMD_START) begin
			ok = m_width[0] && m_height[0] && int'(m_start_x) < nw && int'(m_start_y) < nh &&
				nw <= MDC_MAX_NODES_X && nh <= MDC_MAX_NODES_Y;
			trail_depth = '0;
			if (!ok) begin
				r.kind = KIND_BADCFG;
				return r;
			end
			foreach (node_seen[i])
				node_seen[i] = 1'b0;
			node_seen[int'(m_start_y) * MDC_MAX_NODES_X + int'(m_start_x)] = 1'b1;
			push_node(m_start_x, m_start_y, nw, nh);
			r.kind = KIND_STARTED;
			r.path_x = 6'(2 * int'(m_start_x));
			r.path_y = 6'(2 * int'(m_start_y));
			r.dest_x = r.path_x;
			r.dest_y = r.path_y;
			return r;
		end
		if (trail_depth == 0) begin
			r.kind = KIND_FINISHED;
			return r;
		end
		// try order from the permutation index, lexicographic over l, r, u, d
		fact = '{6, 2, 1, 1};
		pool = '{DIR_L, DIR_R, DIR_U, DIR_D};
		rem = int'(order_idx) % 24;
		for (int i = 0; i < 4; i++) begin
			sel = rem / fact[i];
			rem = rem % fact[i];
			if (sel > 3 - i)
				sel = 3 - i;
			try_dir[i] = pool[sel];
			for (int k = sel; k < 3 - i; k++)
				pool[k] = pool[k + 1];
		end
		cx = trail_x[trail_depth - 1];
		cy = trail_y[trail_depth - 1];
		found = 1'b0;
		dir = DIR_L;
		for (int i = 0; i < 4; i++) begin
			if (!found && trail_dirs[trail_depth - 1][try_dir[i]]) begin
				found = 1'b1;
				dir = try_dir[i];
			end
		end
		if (!found) begin
			trail_depth--;
			r.kind = KIND_POPPED;
			return r;
		end
		trail_dirs[trail_depth - 1][dir] = 1'b0;
		nxt_x = cx;
		nxt_y = cy;
		px = 2 * cx;
		py = 2 * cy;
		in_grid = 1'b1;
		case (dir)
			DIR_L: begin
				if (cx == 0)
					in_grid = 1'b0;
				else begin
					nxt_x = cx - 1;
					px = 2 * cx - 1;
				end
			end
			DIR_R: begin
				nxt_x = cx + 1;
				px = 2 * cx + 1;
			end
			DIR_U: begin
				if (cy == 0)
					in_grid = 1'b0;
				else begin
					nxt_y = cy - 1;
					py = 2 * cy - 1;
				end
			end
			DIR_D: begin
				nxt_y = cy + 1;
				py = 2 * cy + 1;
			end
		endcase
		if (nxt_x >= nw || nxt_y >= nh || nxt_x >= MDC_MAX_NODES_X || nxt_y >= MDC_MAX_NODES_Y)
			in_grid = 1'b0;
		if (!in_grid || node_seen[nxt_y * MDC_MAX_NODES_X + nxt_x]) begin
			r.kind = KIND_BLOCKED;
			return r;
		end
		node_seen[nxt_y * MDC_MAX_NODES_X + nxt_x] = 1'b1;
		push_node(nxt_x, nxt_y, nw, nh);
		r.kind = KIND_CARVED;
		r.path_x = 6'(px);
		r.path_y = 6'(py);
		r.dest_x = 6'(2 * nxt_x);
		r.dest_y = 6'(2 * nxt_y);
		return r;
	endfunction

	task automatic plan_cfg(input logic [1:0] idx, input logic [5:0] val);
		plan_entry_t e;
		e = '{is_cfg: 1'b1, reg_index: idx, value: val, word_cmd: CMD_START, order: 5'd0,
			may_idle: 1'b0};
		word_plan.push_back(e);
	endtask

	task automatic plan_word(input logic word_cmd, input logic [4:0] order);
		plan_entry_t e;
		e = '{is_cfg: 1'b0, reg_index: CFG_MAZE_WIDTH, value: 6'd0, word_cmd: word_cmd,
			order: order, may_idle: plan_idle && planned < CALM_FROM};
		word_plan.push_back(e);
		planned++;
	endtask

	function automatic logic [4:0] rand_order();
		if ($urandom_range(0, 9) == 0)
			return 5'($urandom_range(24, 31));
		return 5'($urandom_range(0, 23));
	endfunction

	// driver
	always @(posedge clk) begin
		logic        nx_start, nx_cmd, nx_we;
		logic [4:0]  nx_order;
		logic [1:0]  nx_index;
		logic [5:0]  nx_wdata;
		plan_entry_t ent;
		if (arst_n) begin
			nx_start = start;
			nx_cmd = cmd;
			nx_order = try_order;
			nx_we = 1'b0;
			nx_index = cfg_index;
			nx_wdata = cfg_wdata;
			if (start && !busy) begin
				maze_events_due.push_back(predict_carve(cmd, try_order));
				nx_start = 1'b0;
				if (cur_may_idle && $urandom_range(0, 99) < 30)
					gap_left = $urandom_range(1, 9);
			end
			if (maze_events_due.size() == 0 && !busy && !done && !start && !cfg_we)
				quiet++;
			else
				quiet = 0;
			if (!nx_start) begin
				if (gap_left > 0)
					gap_left--;
				else if (word_plan.size() > 0) begin
					if (!word_plan[0].is_cfg) begin
						ent = word_plan.pop_front();
						nx_start = 1'b1;
						nx_cmd = ent.word_cmd;
						nx_order = ent.order;
						cur_may_idle = ent.may_idle;
					end else if (quiet >= 3) begin
						ent = word_plan.pop_front();
						nx_we = 1'b1;
						nx_index = ent.reg_index;
						nx_wdata = ent.value;
						apply_config(ent.reg_index, ent.value);
						quiet = 0;
					end
				end
			end
			start <= nx_start;
			cmd <= nx_cmd;
			try_order <= nx_order;
			cfg_we <= nx_we;
			cfg_index <= nx_index;
			cfg_wdata <= nx_wdata;
		end
	end

	// monitor
	always @(posedge clk) begin
		maze_event_t want;
		if (arst_n && done) begin
			if (maze_events_due.size() == 0)
				flag_mismatch("result word with nothing outstanding");
			else begin
				want = maze_events_due.pop_front();
				if (kind !== want.kind)
					flag_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
				if (path_x !== want.path_x)
					flag_mismatch($sformatf("path_x got %0d want %0d", path_x, want.path_x));
				if (path_y !== want.path_y)
					flag_mismatch($sformatf("path_y got %0d want %0d", path_y, want.path_y));
				if (dest_x !== want.dest_x)
					flag_mismatch($sformatf("dest_x got %0d want %0d", dest_x, want.dest_x));
				if (dest_y !== want.dest_y)
					flag_mismatch($sformatf("dest_y got %0d want %0d", dest_y, want.dest_y));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int w, h, sx, sy, n, r;
		// empty stack right after reset
		plan_word(CMD_STEP, 5'd31);
		// smallest grid, walked to the end
		plan_cfg(CFG_MAZE_WIDTH, 6'd3);
		plan_cfg(CFG_MAZE_HEIGHT, 6'd3);
		plan_word(CMD_START, 5'd0);
		plan_word(CMD_STEP, 5'd0);
		plan_word(CMD_STEP, 5'd23);
		plan_word(CMD_STEP, 5'd24);
		plan_word(CMD_STEP, 5'd31);
		plan_word(CMD_STEP, 5'd6);
		plan_word(CMD_STEP, 5'd12);
		plan_word(CMD_STEP, 5'd18);
		plan_word(CMD_STEP, 5'd5);
		plan_word(CMD_STEP, 5'd9);
		plan_word(CMD_STEP, 5'd14);
		plan_word(CMD_STEP, 5'd20);
		plan_word(CMD_STEP, 5'd1);
		plan_word(CMD_STEP, 5'd2);
		// even width, then step on the emptied stack
		plan_cfg(CFG_MAZE_WIDTH, 6'd4);
		plan_word(CMD_START, 5'd0);
		plan_word(CMD_STEP, 5'd0);
		// start node off the grid, then a good corner start and a restart
		plan_cfg(CFG_MAZE_WIDTH, 6'd5);
		plan_cfg(CFG_MAZE_HEIGHT, 6'd5);
		plan_cfg(CFG_START_NODE_X, 6'd3);
		plan_word(CMD_START, 5'd0);
		plan_cfg(CFG_START_NODE_X, 6'd2);
		plan_cfg(CFG_START_NODE_Y, 6'd2);
		plan_word(CMD_START, 5'd0);
		plan_word(CMD_STEP, 5'd16);
		plan_word(CMD_STEP, 5'd7);
		plan_word(CMD_START, 5'd0);
		// largest grid from the far corner, then the grid shrinks under the search
		plan_cfg(CFG_MAZE_WIDTH, 6'd63);
		plan_cfg(CFG_MAZE_HEIGHT, 6'd63);
		plan_cfg(CFG_START_NODE_X, 6'd31);
		plan_cfg(CFG_START_NODE_Y, 6'd31);
		plan_word(CMD_START, 5'd0);
		plan_word(CMD_STEP, 5'd0);
		plan_cfg(CFG_MAZE_WIDTH, 6'd3);
		plan_word(CMD_STEP, 5'd0);

		while (planned < WORD_TARGET) begin
			plan_idle = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				w = 2 * $urandom_range(1, 7) + 1;
				h = 2 * $urandom_range(1, 7) + 1;
			end else if (r < 82) begin
				w = 2 * $urandom_range(1, 31) + 1;
				h = 2 * $urandom_range(1, 31) + 1;
			end else begin
				w = $urandom_range(0, 63);
				h = $urandom_range(0, 63);
			end
			sx = $urandom_range(0, (w + 1) / 2 - 1);
			sy = $urandom_range(0, (h + 1) / 2 - 1);
			if (r >= 82 && $urandom_range(0, 1) == 0) begin
				sx = $urandom_range(0, 31);
				sy = $urandom_range(0, 31);
			end
			plan_cfg(CFG_MAZE_WIDTH, 6'(w));
			plan_cfg(CFG_MAZE_HEIGHT, 6'(h));
			plan_cfg(CFG_START_NODE_X, {1'($urandom_range(0, 1)), 5'(sx)});
			plan_cfg(CFG_START_NODE_Y, {1'($urandom_range(0, 1)), 5'(sy)});
			plan_word(CMD_START, rand_order());
			n = $urandom_range(5, 120);
			for (int i = 0; i < n && planned < WORD_TARGET; i++) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					if ($urandom_range(0, 1) == 0)
						plan_cfg(CFG_MAZE_WIDTH, 6'($urandom_range(0, 63)));
					else
						plan_cfg(CFG_MAZE_HEIGHT, 6'($urandom_range(0, 63)));
				end
				if (r == 99)
					plan_word(CMD_START, rand_order());
				else
					plan_word(CMD_STEP, rand_order());
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (word_plan.size() != 0 || start || cfg_we || done || busy ||
			maze_events_due.size() != 0);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
